>>> rtl/kf25_pkg.sv
// Types, codes and step functions shared by the Keccak-f[25] permutation core.
package kf25_pkg;

  localparam int unsigned LANES      = 25;
  localparam int unsigned CODE_SLOTS = 8;
  localparam int unsigned CODE_W     = 3;

  typedef logic [LANES-1:0]           lanes_t;
  typedef logic [LANES-1:0]           value_t;
  typedef logic [CODE_W-1:0]          step_code_t;
  typedef logic [CODE_SLOTS*CODE_W-1:0] code_seq_t;

  // Step codes; the remaining codes are no operation.
  localparam step_code_t STEP_THETA = 3'd0;
  localparam step_code_t STEP_RHO   = 3'd1;
  localparam step_code_t STEP_PI    = 3'd2;
  localparam step_code_t STEP_CHI   = 3'd3;
  localparam step_code_t STEP_IOTA  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROUND_COUNT = 2'd0;
  localparam logic [1:0] CFG_STEP_COUNT  = 2'd1;
  localparam logic [1:0] CFG_STEP_CODES  = 2'd2;

  localparam logic [4:0]  RESET_ROUND_COUNT = 5'd1;
  localparam logic [3:0]  RESET_STEP_COUNT  = 4'd5;
  localparam code_seq_t   RESET_STEP_CODES  = 24'd18056;

  // Configuration as seen by every round stage.
  typedef struct packed {
    logic [4:0] round_count;
    logic [3:0] step_count;
    code_seq_t  step_codes;
  } cfg_t;

  // Value bit 24-i holds lane i; the mapping is its own inverse.
  function automatic lanes_t bit_reverse(input value_t v);
    lanes_t a;
    for (int i = 0; i < LANES; i++) begin
      a[i] = v[LANES-1-i];
    end
    return a;
  endfunction

  // Round constant bit rc(t) of the x^8+x^6+x^5+x^4+1 LFSR. The sequence
  // has period 255, so stepping t times matches stepping t mod 255 times.
  // Only called with elaboration-time constants.
  function automatic logic rc_bit(input int unsigned t);
    logic [8:0] v;
    logic       hi;
    v = 9'd1;
    for (int unsigned i = 0; i < t; i++) begin
      v  = {v[7:0], 1'b0};
      hi = v[8];
      v  = v ^ {2'b00, hi, hi, hi, 3'b000, hi};
      v  = {1'b0, v[7:0]};
    end
    return v[0];
  endfunction

  function automatic lanes_t do_theta(input lanes_t a);
    logic [4:0] c;
    logic [4:0] d;
    lanes_t     b;
    for (int x = 0; x < 5; x++) begin
      c[x] = a[x] ^ a[5+x] ^ a[10+x] ^ a[15+x] ^ a[20+x];
    end
    for (int x = 0; x < 5; x++) begin
      d[x] = c[(x+4)%5] ^ c[(x+1)%5];
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        b[5*y+x] = a[5*y+x] ^ d[x];
      end
    end
    return b;
  endfunction

  function automatic lanes_t do_pi(input lanes_t a);
    lanes_t b;
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        b[5*y+x] = a[5*x + (x+3*y)%5];
      end
    end
    return b;
  endfunction

  function automatic lanes_t do_chi(input lanes_t a);
    lanes_t b;
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        b[5*y+x] = a[5*y+x] ^ (~a[5*y+(x+1)%5] & a[5*y+(x+2)%5]);
      end
    end
    return b;
  endfunction

  // One step of a round; rc is this round's iota bit.
  function automatic lanes_t apply_step(input lanes_t a, input step_code_t code,
                                        input logic rc);
    lanes_t b;
    b = a;
    unique case (code)
      STEP_THETA: b = do_theta(a);
      STEP_RHO:   b = a;
      STEP_PI:    b = do_pi(a);
      STEP_CHI:   b = do_chi(a);
      STEP_IOTA:  b = {a[LANES-1:1], a[0] ^ rc};
      default:    b = a;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/kf25_stream_if.sv
// Valid/ready channel interfaces for the input and result items.
interface kf25_in_if;
  logic              valid;
  logic              ready;
  kf25_pkg::value_t  start_value;

  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

interface kf25_out_if;
  logic              valid;
  logic              ready;
  kf25_pkg::value_t  permuted_value;

  modport source (output valid, output permuted_value, input ready);
  modport sink   (input valid, input permuted_value, output ready);
endinterface

>>> rtl/keccak_f25_permutation_core.sv
// Keccak-f[25] permutation core: a pipeline of one registered stage per round.
//
// The input channel takes one 25-bit start_value per item; the result
// channel returns its permuted_value in the same order. Each item goes
// through MAX_ROUNDS stages, one per round; a stage whose round is past
// round_count passes the state through. Within a stage, the first
// step_count steps of step_codes, at most SLOTS of them, are applied in order.
// An accepted item passes through the registers of all MAX_ROUNDS stages
// before its result is valid, and one item is accepted every cycle while the
// receiver takes results. The depth of the stage chain sets the latency.
// When the receiver stalls, each stage keeps its item and a stage accepts
// a new item as soon as it or a stage after it is empty, so bubbles are
// squeezed out and nothing is lost or repeated.
// Reset empties every stage and loads round_count 1, step_count 5 and
// step_codes 18056. The configuration port writes register cfg_index with
// cfg_wdata and must be used only while the pipeline is empty.
module keccak_f25_permutation_core #(
  parameter int unsigned MAX_ROUNDS = 24,
  parameter int unsigned MAX_STEPS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  kf25_in_if.sink            in_item,
  kf25_out_if.source         out_item
);

  localparam int unsigned SLOTS =
      (MAX_STEPS < kf25_pkg::CODE_SLOTS) ? MAX_STEPS : kf25_pkg::CODE_SLOTS;

  kf25_pkg::cfg_t   cfg_r;
  logic             stage_valid [MAX_ROUNDS];
  kf25_pkg::lanes_t stage_lanes [MAX_ROUNDS];
  logic             stage_load  [MAX_ROUNDS+1];
  logic             stage_vin   [MAX_ROUNDS];
  kf25_pkg::lanes_t stage_lin   [MAX_ROUNDS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.round_count <= kf25_pkg::RESET_ROUND_COUNT;
      cfg_r.step_count  <= kf25_pkg::RESET_STEP_COUNT;
      cfg_r.step_codes  <= kf25_pkg::RESET_STEP_CODES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kf25_pkg::CFG_ROUND_COUNT: cfg_r.round_count <= cfg_wdata[4:0];
        kf25_pkg::CFG_STEP_COUNT:  cfg_r.step_count  <= cfg_wdata[3:0];
        kf25_pkg::CFG_STEP_CODES:  cfg_r.step_codes  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  assign stage_load[MAX_ROUNDS] = out_item.ready;
  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_load
    assign stage_load[k] = !stage_valid[k] || stage_load[k+1];
  end

  assign in_item.ready = stage_load[0];
  assign stage_vin[0]  = in_item.valid;
  assign stage_lin[0]  = kf25_pkg::bit_reverse(in_item.start_value);

  for (genvar k = 1; k < MAX_ROUNDS; k++) begin : g_link
    assign stage_vin[k] = stage_valid[k-1];
    assign stage_lin[k] = stage_lanes[k-1];
  end

  // One stage per round.
  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_round
    kf25_round_stage #(
      .ROUND_IDX (k),
      .SLOTS     (SLOTS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg_r),
      .load     (stage_load[k]),
      .valid_in (stage_vin[k]),
      .lanes_in (stage_lin[k]),
      .valid_r  (stage_valid[k]),
      .lanes_r  (stage_lanes[k])
    );
  end

  // The last stage is the output register.
  assign out_item.valid          = stage_valid[MAX_ROUNDS-1];
  assign out_item.permuted_value = kf25_pkg::bit_reverse(stage_lanes[MAX_ROUNDS-1]);

endmodule

>>> rtl/kf25_round_stage.sv
// One pipeline stage: applies one configured round and registers the state.
module kf25_round_stage #(
  parameter int unsigned ROUND_IDX = 0,
  parameter int unsigned SLOTS     = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kf25_pkg::cfg_t   cfg,
  input  logic             load,
  input  logic             valid_in,
  input  kf25_pkg::lanes_t lanes_in,
  output logic             valid_r,
  output kf25_pkg::lanes_t lanes_r
);

  localparam logic RC = kf25_pkg::rc_bit(7 * ROUND_IDX);

  kf25_pkg::lanes_t step_st [SLOTS+1];
  kf25_pkg::lanes_t lanes_nxt;
  logic             round_active;

  assign round_active = 32'(cfg.round_count) > 32'(ROUND_IDX);
  assign step_st[0]   = lanes_in;

  // Chain of step units; a step past the configured count passes through.
  for (genvar s = 0; s < SLOTS; s++) begin : g_step
    logic step_active;
    assign step_active = 32'(cfg.step_count) > 32'(s);
    assign step_st[s+1] = step_active
        ? kf25_pkg::apply_step(step_st[s],
                               cfg.step_codes[kf25_pkg::CODE_W*s +: kf25_pkg::CODE_W],
                               RC)
        : step_st[s];
  end

  assign lanes_nxt = round_active ? step_st[SLOTS] : lanes_in;

  // Valid bit, reset to empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (load) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for keccak_f25_permutation_core: directed rows, then random traffic.
module testbench;

  // No-operation step codes.
  localparam kf25_pkg::step_code_t NOP_LO  = 3'd5;
  localparam kf25_pkg::step_code_t NOP_MID = 3'd6;
  localparam kf25_pkg::step_code_t NOP_HI  = 3'd7;

  localparam int unsigned ROUND_LIMIT = 24;
  localparam int unsigned STEP_LIMIT  = 8;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 100;

  localparam kf25_pkg::code_seq_t STD_ROUND = kf25_pkg::RESET_STEP_CODES;
  localparam kf25_pkg::code_seq_t FULL_SEQ  = {kf25_pkg::STEP_THETA, kf25_pkg::STEP_CHI,
                                               kf25_pkg::STEP_IOTA, kf25_pkg::STEP_PI,
                                               kf25_pkg::STEP_RHO, kf25_pkg::STEP_CHI,
                                               kf25_pkg::STEP_PI, kf25_pkg::STEP_THETA};
  localparam kf25_pkg::code_seq_t ALL_NOP   = {8{NOP_HI}};
  localparam kf25_pkg::code_seq_t MIXED_NOP = {NOP_LO, NOP_MID, NOP_HI, NOP_LO,
                                               NOP_MID, NOP_HI, NOP_LO, NOP_MID};

  // One directed row: configuration, input value and, where obvious, the result.
  typedef struct packed {
    logic [4:0]          rounds;
    logic [3:0]          steps;
    kf25_pkg::code_seq_t codes;
    kf25_pkg::value_t    value;
    logic                known;
    kf25_pkg::value_t    want;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 22;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_wdata;

  kf25_in_if  in_ch ();
  kf25_out_if out_ch ();

  keccak_f25_permutation_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_ch),
    .out_item  (out_ch)
  );

  // Shadow copy of the configuration registers.
  logic [4:0]          cur_rounds;
  logic [3:0]          cur_steps;
  kf25_pkg::code_seq_t cur_codes;

  kf25_pkg::value_t pending_values[$];
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  bit               steady;

  plan_row_t plan[PLAN_ROWS];

  always #4 clk = ~clk;

  // Round constant bit rc(t) from the x^8+x^6+x^5+x^4+1 LFSR.
  function automatic logic round_bit(input int unsigned t);
    logic [8:0]  lfsr;
    int unsigned n;
    n = t % 255;
    lfsr = 9'd1;
    for (int unsigned i = 0; i < n; i++) begin
      lfsr = {lfsr[7:0], 1'b0};
      if (lfsr[8]) begin
        lfsr = lfsr ^ 9'h171;
      end
    end
    return lfsr[0];
  endfunction

  // Permuted value for the current configuration.
  function automatic kf25_pkg::value_t permute_value(input kf25_pkg::value_t v);
    logic [24:0]          st;
    logic [24:0]          nx;
    logic [4:0]           par;
    logic                 d;
    int unsigned          rounds;
    int unsigned          steps;
    kf25_pkg::step_code_t code;
    kf25_pkg::value_t     res;
    rounds = (cur_rounds > ROUND_LIMIT) ? ROUND_LIMIT : cur_rounds;
    steps = (cur_steps > STEP_LIMIT) ? STEP_LIMIT : cur_steps;
    for (int i = 0; i < 25; i++) begin
      st[i] = v[24-i];
    end
    for (int unsigned r = 0; r < rounds; r++) begin
      for (int unsigned s = 0; s < steps; s++) begin
        code = cur_codes[3*s +: 3];
        nx = st;
        case (code)
          kf25_pkg::STEP_THETA: begin
            for (int x = 0; x < 5; x++) begin
              par[x] = st[x] ^ st[5+x] ^ st[10+x] ^ st[15+x] ^ st[20+x];
            end
            for (int x = 0; x < 5; x++) begin
              d = par[(x+4)%5] ^ par[(x+1)%5];
              for (int y = 0; y < 5; y++) begin
                nx[5*y+x] = st[5*y+x] ^ d;
              end
            end
          end
          kf25_pkg::STEP_PI: begin
            for (int x = 0; x < 5; x++) begin
              for (int y = 0; y < 5; y++) begin
                nx[5*y+x] = st[5*x + (x+3*y)%5];
              end
            end
          end
          kf25_pkg::STEP_CHI: begin
            for (int y = 0; y < 5; y++) begin
              for (int x = 0; x < 5; x++) begin
                nx[5*y+x] = st[5*y+x] ^ (~st[5*y+(x+1)%5] & st[5*y+(x+2)%5]);
              end
            end
          end
          kf25_pkg::STEP_IOTA: begin
            nx[0] = st[0] ^ round_bit(7*r);
          end
          default: begin
            nx = st;
          end
        endcase
        st = nx;
      end
    end
    for (int i = 0; i < 25; i++) begin
      res[24-i] = st[i];
    end
    return res;
  endfunction

  // Offer one item, with random idle cycles ahead of it outside the steady stretch; called at a falling edge.
  task automatic offer_value(input kf25_pkg::value_t v, input logic known,
                             input kf25_pkg::value_t want);
    while (!steady && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      in_ch.start_value <= kf25_pkg::value_t'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_value <= v;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_values.push_back(known ? want : permute_value(v));
    @(negedge clk);
  endtask

  // Stop sending and wait until every result is back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Write all three registers on consecutive cycles.
  task automatic load_config(input logic [4:0] rounds, input logic [3:0] steps,
                             input kf25_pkg::code_seq_t codes);
    cfg_we <= 1'b1;
    cfg_index <= kf25_pkg::CFG_ROUND_COUNT;
    cfg_wdata <= 24'(rounds);
    @(negedge clk);
    cfg_index <= kf25_pkg::CFG_STEP_COUNT;
    cfg_wdata <= 24'(steps);
    @(negedge clk);
    cfg_index <= kf25_pkg::CFG_STEP_CODES;
    cfg_wdata <= codes;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_rounds = rounds;
    cur_steps = steps;
    cur_codes = codes;
  endtask

  // Receiver stalls at random except in the steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Compare every result with the oldest expected value.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time,
                 out_ch.permuted_value);
        mismatches++;
      end else begin
        if (out_ch.permuted_value !== pending_values[0]) begin
          $display("%0t: permuted_value expected %h got %h", $time,
                   pending_values[0], out_ch.permuted_value);
          mismatches++;
        end
        void'(pending_values.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("keccak_f25_permutation_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0]          rounds;
    logic [3:0]          steps;
    kf25_pkg::code_seq_t codes;
    kf25_pkg::value_t    v;
    int unsigned         pick;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = kf25_pkg::CFG_ROUND_COUNT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.start_value = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    cur_rounds = kf25_pkg::RESET_ROUND_COUNT;
    cur_steps = kf25_pkg::RESET_STEP_COUNT;
    cur_codes = kf25_pkg::RESET_STEP_CODES;

    // Directed rows: reset settings, pass-through cases, single steps, saturation.
    plan = '{
      '{5'd1,  4'd5,  STD_ROUND,                  25'h0000000, 1'b1, 25'h1000000},
      '{5'd1,  4'd5,  STD_ROUND,                  25'h1FFFFFF, 1'b0, 25'h0},
      '{5'd1,  4'd5,  STD_ROUND,                  25'h0000001, 1'b0, 25'h0},
      '{5'd1,  4'd5,  STD_ROUND,                  25'h1000000, 1'b0, 25'h0},
      '{5'd0,  4'd5,  STD_ROUND,                  25'h1FFFFFF, 1'b1, 25'h1FFFFFF},
      '{5'd0,  4'd5,  STD_ROUND,                  25'h0AAAAAA, 1'b1, 25'h0AAAAAA},
      '{5'd24, 4'd0,  STD_ROUND,                  25'h1555555, 1'b1, 25'h1555555},
      '{5'd24, 4'd8,  ALL_NOP,                    25'h1234567, 1'b1, 25'h1234567},
      '{5'd24, 4'd8,  MIXED_NOP,                  25'h0FEDCBA, 1'b1, 25'h0FEDCBA},
      '{5'd1,  4'd1,  {8{kf25_pkg::STEP_THETA}},  25'h0000001, 1'b0, 25'h0},
      '{5'd1,  4'd1,  {8{kf25_pkg::STEP_THETA}},  25'h1000000, 1'b0, 25'h0},
      '{5'd1,  4'd1,  {8{kf25_pkg::STEP_PI}},     25'h0F0F0F0, 1'b0, 25'h0},
      '{5'd1,  4'd1,  {8{kf25_pkg::STEP_CHI}},    25'h1FFFFFF, 1'b0, 25'h0},
      '{5'd1,  4'd1,  {8{kf25_pkg::STEP_CHI}},    25'h0C30C30, 1'b0, 25'h0},
      '{5'd3,  4'd8,  {8{kf25_pkg::STEP_RHO}},    25'h1ABCDEF, 1'b1, 25'h1ABCDEF},
      '{5'd24, 4'd1,  {8{kf25_pkg::STEP_IOTA}},   25'h0000000, 1'b0, 25'h0},
      '{5'd24, 4'd8,  FULL_SEQ,                   25'h1FFFFFF, 1'b0, 25'h0},
      '{5'd24, 4'd8,  FULL_SEQ,                   25'h0000000, 1'b0, 25'h0},
      '{5'd31, 4'd15, FULL_SEQ,                   25'h0123456, 1'b0, 25'h0},
      '{5'd31, 4'd15, {8{kf25_pkg::STEP_THETA}},  25'h1FFFFFF, 1'b0, 25'h0},
      '{5'd24, 4'd5,  STD_ROUND,                  25'h0000000, 1'b0, 25'h0},
      '{5'd24, 4'd5,  STD_ROUND,                  25'h1FFFFFF, 1'b0, 25'h0}
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int unsigned i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].rounds != cur_rounds || plan[i].steps != cur_steps ||
          plan[i].codes != cur_codes) begin
        drain_results();
        load_config(plan[i].rounds, plan[i].steps, plan[i].codes);
      end
      offer_value(plan[i].value, plan[i].known, plan[i].want);
    end

    // Random phases, each with fresh settings; the second one runs without stalls.
    for (int unsigned p = 0; p < PHASES; p++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        rounds = 5'd24;
      end else if (pick == 1) begin
        rounds = 5'($urandom_range(31, 25));
      end else if (pick == 2) begin
        rounds = 5'd0;
      end else begin
        rounds = 5'($urandom_range(24, 1));
      end
      pick = $urandom_range(9);
      steps = (pick < 5) ? 4'd8 : 4'($urandom_range(15));
      pick = $urandom_range(3);
      if (pick == 0) begin
        codes = STD_ROUND;
      end else if (pick == 1) begin
        codes = FULL_SEQ;
      end else begin
        codes = kf25_pkg::code_seq_t'($urandom);
      end
      drain_results();
      load_config(rounds, steps, codes);
      steady = (p == 1);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(19);
        if (pick == 0) begin
          v = kf25_pkg::value_t'(1) << $urandom_range(24);
        end else if (pick == 1) begin
          v = '1;
        end else if (pick == 2) begin
          v = '0;
        end else begin
          v = kf25_pkg::value_t'($urandom);
        end
        offer_value(v, 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Let the pipeline empty, then watch a while for stray results.
    drain_results();
    repeat (2 * ROUND_LIMIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("keccak_f25_permutation_core: match");
    end else begin
      $display("keccak_f25_permutation_core: mismatch");
    end
    $finish;
  end

endmodule
